>>> sv/cte_pkg.sv
// Shared types, widths and constant tables for the calendar to epoch time unit.
// Used by cte_calendar, cte_scale and calendar_to_epoch_time_unit; depends on nothing.
package cte_pkg;

  localparam int YearW  = 14;
  localparam int DaysW  = 24;
  localparam int SodW   = 19;
  localparam int FracW  = 30;
  localparam int TotalW = 41;
  localparam int ScaleW = 50;
  localparam int HalfW  = 25;
  localparam int ProdW  = TotalW + HalfW + 1;
  localparam int ExactW = ProdW + HalfW + 1;
  localparam int TsW    = 64;

  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [3:0] February  = 4'd1;

  // Day count of 1970-01-01 relative to the biased leap-day sum, including the one
  // subtracted for a day of month that starts at 1.
  localparam logic [DaysW-1:0] DayBias = 24'd719625;

  // Offset that keeps the year minus one positive before the leap-day divisions.
  localparam logic [14:0] YearShift = 15'd399;

  localparam logic [12:0] Recip25 = 13'd5243;
  localparam int Recip25Shift = 17;

  typedef struct packed {
    logic                    valid;
    logic signed [DaysW-1:0] days;
    logic signed [SodW-1:0]  sod;
    logic [FracW-1:0]        frac;
  } cte_sec_t;

  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] r;
    unique case (mon)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic [ScaleW-1:0] pow10(input logic [3:0] p);
    logic [ScaleW-1:0] r;
    unique case (p)
      4'd0:    r = 50'd1;
      4'd1:    r = 50'd10;
      4'd2:    r = 50'd100;
      4'd3:    r = 50'd1000;
      4'd4:    r = 50'd10000;
      4'd5:    r = 50'd100000;
      4'd6:    r = 50'd1000000;
      4'd7:    r = 50'd10000000;
      4'd8:    r = 50'd100000000;
      4'd9:    r = 50'd1000000000;
      4'd10:   r = 50'd10000000000;
      4'd11:   r = 50'd100000000000;
      4'd12:   r = 50'd1000000000000;
      4'd13:   r = 50'd10000000000000;
      4'd14:   r = 50'd100000000000000;
      default: r = 50'd1000000000000000;
    endcase
    return r;
  endfunction

  // Floor division by 25 through a scaled reciprocal, exact for all 15-bit inputs.
  function automatic logic [10:0] div25(input logic [14:0] x);
    logic [27:0] prod;
    prod = {13'd0, x} * {15'd0, Recip25};
    return prod[27:Recip25Shift];
  endfunction

endpackage

>>> sv/calendar_to_epoch_time_unit.sv
// Calendar to epoch time unit: converts a UTC calendar time into scaled epoch time.
// An accepted request reaches its done strobe through the five register stages
// (divisions, day count, seconds, split multiply, final sum).
// Throughput is one request per cycle; busy stays low since the receiver cannot stall.
// Reset clears all valid bits and sets the precision register to 0.
// Depends on cte_pkg, cte_calendar and cte_scale.
module calendar_to_epoch_time_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               precision_we,
  input  logic [3:0]         precision_wdata,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day_of_month,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic signed [17:0] utc_offset,
  input  logic [29:0]        fraction,
  output logic               done,
  output logic signed [63:0] timestamp,
  output logic               overflow
);
  import cte_pkg::*;

  logic [3:0] precision_digits;
  cte_sec_t   sec;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision_digits <= 4'd0;
    end else if (precision_we) begin
      precision_digits <= precision_wdata;
    end
  end

  cte_calendar u_calendar (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .utc_offset   (utc_offset),
    .fraction     (fraction),
    .sec_out      (sec)
  );

  cte_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .sec_in    (sec),
    .precision (precision_digits),
    .out_valid (done),
    .timestamp (timestamp),
    .overflow  (overflow)
  );

endmodule

>>> sv/cte_calendar.sv
// Calendar stages: leap-day divisions, then day count and second of day.
// Depends on cte_pkg.
module cte_calendar (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [13:0]           year,
  input  logic [3:0]            month,
  input  logic [4:0]            day_of_month,
  input  logic [4:0]            hour,
  input  logic [5:0]            minute,
  input  logic [5:0]            second,
  input  logic signed [17:0]    utc_offset,
  input  logic [29:0]           fraction,
  output cte_pkg::cte_sec_t     sec_out
);
  import cte_pkg::*;

  logic [14:0] shifted_year;
  logic        s1_valid;
  logic [YearW-1:0] s1_year;
  logic [12:0] s1_quart;
  logic [10:0] s1_q100;
  logic [10:0] s1_q400;
  logic [10:0] s1_q25;
  logic [3:0]  s1_mon;
  logic [4:0]  s1_mday;
  logic [4:0]  s1_hour;
  logic [5:0]  s1_min;
  logic [5:0]  s1_sec;
  logic [17:0] s1_off;
  logic [FracW-1:0] s1_frac;

  logic        div_by_25;
  logic        leap;
  logic        leap_adj;
  logic [DaysW-1:0] year_days;
  logic [DaysW-1:0] days_next;
  logic [SodW-1:0]  sod_next;

  assign shifted_year = {1'b0, year} + YearShift;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_year  <= year;
    s1_quart <= shifted_year[14:2];
    s1_q100  <= div25({2'b0, shifted_year[14:2]});
    s1_q400  <= div25({4'b0, shifted_year[14:4]});
    s1_q25   <= div25({1'b0, year});
    s1_mon   <= (month > LastMonth) ? LastMonth : month;
    s1_mday  <= day_of_month;
    s1_hour  <= hour;
    s1_min   <= minute;
    s1_sec   <= second;
    s1_off   <= utc_offset;
    s1_frac  <= fraction;
  end

  always_comb begin
    div_by_25 = (s1_year == 14'({3'b0, s1_q25} * 14'd25));
    leap      = (s1_year[1:0] == 2'b00) && (!div_by_25 || (s1_year[3:0] == 4'b0000));
    leap_adj  = (s1_mon > February) && leap;
    year_days = {10'd0, s1_year} * 24'd365;
    days_next = year_days + {11'd0, s1_quart} - {13'd0, s1_q100} + {13'd0, s1_q400}
              + {15'd0, month_start(s1_mon)} + {23'd0, leap_adj} + {19'd0, s1_mday}
              - DayBias;
    sod_next  = {14'd0, s1_hour} * 19'd3600 + {13'd0, s1_min} * 19'd60 + {13'd0, s1_sec}
              - {s1_off[17], s1_off};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_out.valid <= 1'b0;
    end else begin
      sec_out.valid <= s1_valid;
    end
    sec_out.days <= $signed(days_next);
    sec_out.sod  <= $signed(sod_next);
    sec_out.frac <= s1_frac;
  end

endmodule

>>> sv/cte_scale.sv
// Scaling stages: total seconds, split product by the power of ten, final sum
// with overflow detection. Depends on cte_pkg.
module cte_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  cte_pkg::cte_sec_t     sec_in,
  input  logic [3:0]            precision,
  output logic                  out_valid,
  output logic signed [63:0]    timestamp,
  output logic                  overflow
);
  import cte_pkg::*;

  logic                     s3_valid;
  logic signed [TotalW-1:0] s3_total;
  logic [FracW-1:0]         s3_frac;
  logic signed [TotalW-1:0] days_ext;
  logic signed [TotalW-1:0] sod_ext;

  logic [ScaleW-1:0]        scale;
  logic signed [ProdW-1:0]  total_ext;
  logic                     s4_valid;
  logic signed [ProdW-1:0]  s4_p_lo;
  logic signed [ProdW-1:0]  s4_p_hi;
  logic [FracW-1:0]         s4_frac;

  logic [ExactW-1:0]        exact;

  assign days_ext = {{(TotalW - DaysW){sec_in.days[DaysW-1]}}, sec_in.days};
  assign sod_ext  = {{(TotalW - SodW){sec_in.sod[SodW-1]}}, sec_in.sod};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= sec_in.valid;
    end
    s3_total <= days_ext * 41'sd86400 + sod_ext;
    s3_frac  <= sec_in.frac;
  end

  assign scale     = pow10(precision);
  assign total_ext = {{(ProdW - TotalW){s3_total[TotalW-1]}}, s3_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_p_lo <= total_ext * $signed({{(ProdW - HalfW){1'b0}}, scale[HalfW-1:0]});
    s4_p_hi <= total_ext * $signed({{(ProdW - HalfW){1'b0}}, scale[ScaleW-1:HalfW]});
    s4_frac <= s3_frac;
  end

  always_comb begin
    exact = ({{(ExactW - ProdW){s4_p_hi[ProdW-1]}}, s4_p_hi} << HalfW)
          + {{(ExactW - ProdW){s4_p_lo[ProdW-1]}}, s4_p_lo}
          + {{(ExactW - FracW){1'b0}}, s4_frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_valid;
    end
    timestamp <= $signed(exact[TsW-1:0]);
    overflow  <= !((&exact[ExactW-1:TsW-1]) || !(|exact[ExactW-1:TsW-1]));
  end

endmodule
